@@ hdl/srfc_pkg.sv @@
// srfc_pkg: types, constants and the crc byte update for the sensor reply frame checker
// no dependencies; imported by sensor_reply_frame_checker
`default_nettype none

package srfc_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = 4;                 // holds 0..8
    localparam int PAYLOAD_N   = 5;                 // bytes 2..6 of a frame
    localparam int PAYLOAD_W   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;                // 33 bits of fields padded to bytes
    localparam int M_TUSER_W   = 2;
    localparam int LIMIT10_W   = 12;                // 255 * 10 fits in 12 bits

    localparam logic [POS_W-1:0] NO_FRAME   = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(6);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(7);
    localparam logic [POS_W-1:0] POS_HUM_HI = POS_W'(2);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_BUS_FAIL = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_LO = 2'd0,
        CFG_TEMP_HI = 2'd1,
        CFG_HUM_LO  = 2'd2,
        CFG_HUM_HI  = 2'd3
    } cfg_index_t;

    // crc-16/modbus over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // whole units to tenths: x*8 + x*2
    function automatic logic [LIMIT10_W-1:0] times_ten(input logic [7:0] x);
        return {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ hdl/sensor_reply_frame_checker.sv @@
// sensor_reply_frame_checker: crc and range check of an 8-byte sensor reply
// depends on srfc_pkg (hdl/srfc_pkg.sv)
`default_nettype none

// Takes one reply byte per input beat and gives one result beat per finished
// frame or abort. A beat with tuser[1] set opens a new frame as byte 0; bytes
// 2..3 are humidity and 4..5 temperature (big-endian), 6..7 the CRC-16/MODBUS
// of bytes 0..5, low byte first. A beat with tuser[0] set reports a bus read
// failure at once and closes any open frame. Bytes outside an open frame are
// dropped. Each byte passes through the input register before its outcome
// lands in the result register, so a result beat is valid only once byte 7
// has gone through both registers; one beat is accepted every cycle while the
// result side takes its beats, the crc being an unrolled one-byte update. Limits
// are to be written only while idle; the user is bound, the block does not enforce it.

module sensor_reply_frame_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [srfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [srfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // reply bytes
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [srfc_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [srfc_pkg::S_TUSER_W-1:0]   s_axis_tuser,   // [0] kind, [1] frame_first
    // results
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [srfc_pkg::M_TDATA_W-1:0]        m_axis_tdata,   // [15:0] temperature_word,
                                                                  // [31:16] humidity_word,
                                                                  // [32] ambient_normal, rest 0
    output logic [srfc_pkg::M_TUSER_W-1:0]        m_axis_tuser    // [1:0] read_status
);
    import srfc_pkg::*;

    // limits
    logic [7:0] temp_lo_reg, temp_hi_reg, hum_lo_reg, hum_hi_reg;

    // input register
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic       in_first_reg;
    logic [7:0] in_byte_reg;

    // frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       payload_reg [PAYLOAD_N];

    // result register
    logic        m_valid_reg, m_valid_next;
    status_t     m_status_reg, m_status_next;
    logic [15:0] m_temp_reg, m_temp_next;
    logic [15:0] m_hum_reg, m_hum_next;
    logic        m_amb_reg, m_amb_next;

    logic             advance;
    logic             take_in;
    logic             pay_we;
    logic [PAYLOAD_W-1:0] pay_idx;
    logic [POS_W-1:0] eff_pos;
    logic [15:0]      eff_crc;
    logic [15:0]      hum_word, temp_word, rx_crc;
    logic             temp_in, hum_in;

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign hum_word  = {payload_reg[0], payload_reg[1]};
    assign temp_word = {payload_reg[2], payload_reg[3]};
    assign rx_crc    = {in_byte_reg, payload_reg[4]};

    assign temp_in = (temp_word > {4'h0, times_ten(temp_lo_reg)}) &&
                     (temp_word < {4'h0, times_ten(temp_hi_reg)});
    assign hum_in  = (hum_word > {4'h0, times_ten(hum_lo_reg)}) &&
                     (hum_word < {4'h0, times_ten(hum_hi_reg)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_lo_reg <= 8'd0;
            temp_hi_reg <= 8'd50;
            hum_lo_reg  <= 8'd0;
            hum_hi_reg  <= 8'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TEMP_LO: temp_lo_reg <= cfg_wdata;
                CFG_TEMP_HI: temp_hi_reg <= cfg_wdata;
                CFG_HUM_LO:  hum_lo_reg  <= cfg_wdata;
                CFG_HUM_HI:  hum_hi_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_kind_reg  <= s_axis_tuser[0];
            in_first_reg <= s_axis_tuser[1];
            in_byte_reg  <= s_axis_tdata[7:0];
        end
    end

    // frame logic on the item in the input register
    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        pay_we        = 1'b0;
        eff_pos       = in_first_reg ? '0 : pos_reg;
        eff_crc       = in_first_reg ? CRC_INIT : crc_reg;
        pay_idx       = PAYLOAD_W'(eff_pos - POS_HUM_HI);
        m_valid_next  = advance ? 1'b0 : m_valid_reg;
        m_status_next = m_status_reg;
        m_temp_next   = m_temp_reg;
        m_hum_next    = m_hum_reg;
        m_amb_next    = m_amb_reg;

        if (in_valid_reg && advance) begin
            if (in_kind_reg) begin
                pos_next      = NO_FRAME;
                crc_next      = CRC_INIT;
                m_valid_next  = 1'b1;
                m_status_next = ST_BUS_FAIL;
                m_temp_next   = '0;
                m_hum_next    = '0;
                m_amb_next    = 1'b0;
            end else if (eff_pos < POS_CRC_LO) begin
                crc_next = crc_byte(eff_crc, in_byte_reg);
                pay_we   = (eff_pos >= POS_HUM_HI);
                pos_next = eff_pos + POS_W'(1);
            end else if (eff_pos == POS_CRC_LO) begin
                crc_next = eff_crc;
                pay_we   = 1'b1;
                pos_next = eff_pos + POS_W'(1);
            end else if (eff_pos == POS_CRC_HI) begin
                pos_next      = NO_FRAME;
                crc_next      = CRC_INIT;
                m_valid_next  = 1'b1;
                m_status_next = (rx_crc == eff_crc) ? ST_OK : ST_CRC_ERR;
                m_temp_next   = temp_word;
                m_hum_next    = hum_word;
                m_amb_next    = temp_in && hum_in;
            end
            // stray byte outside a frame: nothing
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= NO_FRAME;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pay_we) begin
            payload_reg[pay_idx] <= in_byte_reg;
        end
        m_status_reg <= m_status_next;
        m_temp_reg   <= m_temp_next;
        m_hum_reg    <= m_hum_next;
        m_amb_reg    <= m_amb_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {7'd0, m_amb_reg, m_hum_reg, m_temp_reg};

    // closed frame always leaves the crc seeded
    a_idle_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == NO_FRAME |-> crc_reg == CRC_INIT)
        else $error("crc not reseeded with no frame open");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= NO_FRAME)
        else $error("byte position out of range");

    a_abort_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_kind_reg && advance |=>
            m_valid_reg && m_status_reg == ST_BUS_FAIL && pos_reg == NO_FRAME)
        else $error("abort beat did not give a bus failure result");

    a_abort_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ST_BUS_FAIL |-> m_axis_tdata == '0)
        else $error("bus failure result carries data");

endmodule

`default_nettype wire

@@ verif/tb_sensor_reply_frame_checker.sv @@
`timescale 1ns / 100ps
// tb_sensor_reply_frame_checker: directed script plus random reply streams with a bit-true
// frame tracker, result beats checked in order against the tracked readings
// depends on srfc_pkg and sensor_reply_frame_checker (hdl/)

module tb_sensor_reply_frame_checker;
    import srfc_pkg::*;

    localparam int PHASES       = 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        status_t     status;
        logic [15:0] temp;
        logic [15:0] hum;
        logic        amb;
    } reading_t;

    // how a script row fills its data byte
    typedef enum logic [1:0] {
        CRC_RAW,
        CRC_LOW_BYTE,
        CRC_HIGH_BYTE,
        CRC_HIGH_BROKEN
    } crc_fill_t;

    typedef struct packed {
        logic      kind;
        logic      first;
        logic [7:0] data;
        crc_fill_t fill;
        logic      typed;
        reading_t  want;
    } script_row_t;

    localparam reading_t NO_READING   = '{ST_OK, 16'h0000, 16'h0000, 1'b0};
    localparam reading_t BUS_READING  = '{ST_BUS_FAIL, 16'h0000, 16'h0000, 1'b0};
    localparam reading_t GOOD_READING = '{ST_OK, 16'd250, 16'd500, 1'b1};
    localparam reading_t MAX_READING  = '{ST_CRC_ERR, 16'hFFFF, 16'hFFFF, 1'b0};

    logic aclk;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = CFG_TEMP_LO;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;   // [0] kind, [1] frame_first

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // tracked block state
    logic [POS_W-1:0] frame_pos = NO_FRAME;
    logic [15:0]      crc_acc   = CRC_INIT;
    logic [7:0]       payload [PAYLOAD_N];
    logic [7:0]       lim_t_lo = 8'd0;
    logic [7:0]       lim_t_hi = 8'd50;
    logic [7:0]       lim_h_lo = 8'd0;
    logic [7:0]       lim_h_hi = 8'd100;

    reading_t    pending_readings [$];
    int unsigned items_used = 0;
    int unsigned mismatches = 0;
    bit          quiet = 1'b0;

    logic [7:0]  next_limits [4];
    cfg_index_t  reg_order [4] = '{CFG_TEMP_LO, CFG_TEMP_HI, CFG_HUM_LO, CFG_HUM_HI};

    script_row_t directed_script [23] = '{
        // stray byte with no frame open
        '{1'b0, 1'b0, 8'hFF, CRC_RAW, 1'b0, NO_READING},
        // two bytes, then dropped by a restart
        '{1'b0, 1'b1, 8'h03, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h04, CRC_RAW, 1'b0, NO_READING},
        // 50.0 % and 25.0 degrees, good crc
        '{1'b0, 1'b1, 8'h03, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h04, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h01, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hF4, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h00, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hFA, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h00, CRC_LOW_BYTE, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h00, CRC_HIGH_BYTE, 1'b1, GOOD_READING},
        // all-ones words, broken crc
        '{1'b0, 1'b1, 8'h00, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hFF, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hFF, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hFF, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hFF, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hFF, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h00, CRC_LOW_BYTE, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'h00, CRC_HIGH_BROKEN, 1'b1, MAX_READING},
        // abort in the middle of a frame, then abort with nothing open
        '{1'b0, 1'b1, 8'h55, CRC_RAW, 1'b0, NO_READING},
        '{1'b0, 1'b0, 8'hAA, CRC_RAW, 1'b0, NO_READING},
        '{1'b1, 1'b1, 8'hFF, CRC_RAW, 1'b1, BUS_READING},
        '{1'b1, 1'b0, 8'h00, CRC_RAW, 1'b1, BUS_READING}
    };

    sensor_reply_frame_checker u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_modbus_update(input logic [15:0] acc,
                                                        input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // raw tenths strictly between the whole-unit limits
    function automatic bit in_band(input logic [15:0] raw, input logic [7:0] lo,
                                   input logic [7:0] hi);
        return int'(raw) > int'(lo) * 10 && int'(raw) < int'(hi) * 10;
    endfunction

    function automatic void advance_frame(input logic kind, input logic [7:0] data,
                                          input logic first, output bit produced,
                                          output bit dropped, output reading_t r);
        logic [15:0] rx_crc;
        produced = 1'b0;
        dropped  = 1'b0;
        r = BUS_READING;
        if (kind) begin
            frame_pos = NO_FRAME;
            crc_acc   = CRC_INIT;
            produced  = 1'b1;
            return;
        end
        if (first) begin
            frame_pos = '0;
            crc_acc   = CRC_INIT;
        end else if (frame_pos == NO_FRAME) begin
            dropped = 1'b1;
            return;
        end
        if (frame_pos < POS_CRC_LO) begin
            crc_acc = crc16_modbus_update(crc_acc, data);
            if (frame_pos >= POS_HUM_HI) begin
                payload[frame_pos - POS_HUM_HI] = data;
            end
            frame_pos++;
        end else if (frame_pos == POS_CRC_LO) begin
            payload[PAYLOAD_N-1] = data;
            frame_pos++;
        end else begin
            frame_pos = NO_FRAME;
            rx_crc    = {data, payload[PAYLOAD_N-1]};
            r.hum     = {payload[0], payload[1]};
            r.temp    = {payload[2], payload[3]};
            r.status  = (rx_crc == crc_acc) ? ST_OK : ST_CRC_ERR;
            r.amb     = in_band(r.temp, lim_t_lo, lim_t_hi) && in_band(r.hum, lim_h_lo, lim_h_hi);
            crc_acc   = CRC_INIT;
            produced  = 1'b1;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // word that lands near the edges or inside of a limit window often enough
    function automatic logic [15:0] pick_word(input logic [7:0] lo, input logic [7:0] hi);
        int lo10;
        int hi10;
        lo10 = int'(lo) * 10;
        hi10 = int'(hi) * 10;
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'(lo10 + int'($urandom_range(0, 2)) - 1);
            2: return 16'(hi10 + int'($urandom_range(0, 2)) - 1);
            5: return 16'($urandom_range(0, 2600));
            default: begin
                if (hi10 - lo10 >= 2) return 16'($urandom_range(lo10 + 1, hi10 - 1));
                return 16'($urandom_range(0, 2600));
            end
        endcase
    endfunction

    function automatic void note_diff(input string field, input logic [15:0] exp,
                                      input logic [15:0] act);
        if (act !== exp) begin
            $display("%0t: %s expected %h got %h", $time, field, exp, act);
            mismatches++;
        end
    endfunction

    task automatic feed_byte(input logic kind, input logic [7:0] data, input logic first,
                             input bit use_typed, input reading_t typed_want);
        bit          produced;
        bit          dropped;
        reading_t    r;
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {first, kind};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        advance_frame(kind, data, first, produced, dropped, r);
        if (use_typed) begin
            pending_readings.push_back(typed_want);
        end else if (produced) begin
            pending_readings.push_back(r);
        end
        if (!dropped) items_used++;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_sequence();
        logic [7:0]  frame [8];
        logic [15:0] crc;
        logic [15:0] hum;
        logic [15:0] temp;
        int unsigned pick;
        int unsigned cut;
        int unsigned restart_at;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            feed_byte(1'b0, 8'($urandom), 1'b0, 1'b0, NO_READING);
            return;
        end
        if (pick < 14) begin
            feed_byte(1'b1, 8'($urandom), 1'($urandom), 1'b0, NO_READING);
            return;
        end
        frame[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h03;
        frame[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h04;
        hum  = pick_word(lim_h_lo, lim_h_hi);
        temp = pick_word(lim_t_lo, lim_t_hi);
        frame[2] = hum[15:8];
        frame[3] = hum[7:0];
        frame[4] = temp[15:8];
        frame[5] = temp[7:0];
        crc = CRC_INIT;
        for (int k = 0; k < 6; k++) crc = crc16_modbus_update(crc, frame[k]);
        if ($urandom_range(0, 4) == 0) crc ^= 16'($urandom_range(1, 65535));
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        cut = (pick < 24) ? $urandom_range(1, 7) : 8;
        // a restart flag landing inside the frame
        restart_at = (pick >= 24 && pick < 28) ? $urandom_range(1, 7) : 0;
        for (int k = 0; k < cut; k++) begin
            feed_byte(1'b0, frame[k], (k == 0) || (k == restart_at), 1'b0, NO_READING);
        end
        if (pick < 19) feed_byte(1'b1, 8'($urandom), 1'($urandom), 1'b0, NO_READING);
    endtask

    // idle the input side and let every pending result drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limits();
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_index <= reg_order[i];
            cfg_wdata <= next_limits[i];
            @(posedge aclk);
            case (reg_order[i])
                CFG_TEMP_LO: lim_t_lo = next_limits[i];
                CFG_TEMP_HI: lim_t_hi = next_limits[i];
                CFG_HUM_LO:  lim_h_lo = next_limits[i];
                default:     lim_h_hi = next_limits[i];
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : result_pacing
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : result_check
        reading_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result beat with none pending, tuser %h tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                note_diff("read_status", 16'(want.status), 16'(m_axis_tuser));
                note_diff("temperature_word", want.temp, m_axis_tdata[15:0]);
                note_diff("humidity_word", want.hum, m_axis_tdata[31:16]);
                note_diff("ambient_normal", 16'(want.amb), 16'(m_axis_tdata[32]));
                note_diff("tdata padding", 16'h0000, 16'(m_axis_tdata[M_TDATA_W-1:33]));
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        script_row_t row;
        logic [7:0]  beat_data;
        int unsigned target;
        for (int i = 0; i < PAYLOAD_N; i++) payload[i] = 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_script[i]) begin
            row = directed_script[i];
            case (row.fill)
                CRC_LOW_BYTE:    beat_data = crc_acc[7:0];
                CRC_HIGH_BYTE:   beat_data = crc_acc[15:8];
                CRC_HIGH_BROKEN: beat_data = crc_acc[15:8] ^ 8'h01;
                default:         beat_data = row.data;
            endcase
            feed_byte(row.kind, beat_data, row.first, row.typed, row.want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph != 0) begin
                case (ph)
                    1: next_limits = '{8'd0, 8'd255, 8'd0, 8'd255};
                    2: next_limits = '{8'd255, 8'd0, 8'd255, 8'd0};      // inverted
                    3: next_limits = '{8'd20, 8'd30, 8'd40, 8'd60};
                    4: next_limits = '{8'd255, 8'd255, 8'd255, 8'd255};
                    5: begin
                        next_limits[0] = 8'($urandom_range(0, 100));
                        next_limits[1] = 8'($urandom_range(int'(next_limits[0]) + 1, 255));
                        next_limits[2] = 8'($urandom_range(0, 100));
                        next_limits[3] = 8'($urandom_range(int'(next_limits[2]) + 1, 255));
                    end
                    6: for (int i = 0; i < 4; i++) next_limits[i] = 8'($urandom);
                    default: next_limits = '{8'd0, 8'd50, 8'd0, 8'd100};
                endcase
                write_limits();
            end
            quiet  = (ph == 3) || (ph == 6);
            target = items_used + RANDOM_ITEMS / PHASES;
            while (items_used < target) send_random_sequence();
        end
        settle();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
